### rtl/sek_pkg.sv
// Shared types, constants and the 2^-x table function for the squared
// exponential kernel block. No dependencies.
package sek_pkg;

  localparam int SUM_W  = 40;  // distance accumulator, unsigned Q24.16
  localparam int NUM_W  = 58;  // divider dividend width
  localparam int DEN_W  = 34;  // divider divisor width
  localparam int T_W    = 33;  // scaled distance t, Q.16, clamped to 2^32
  localparam int E_W    = 33;  // exponential, Q.32
  localparam int P_W    = 25;  // var * E, Q.16
  localparam int ROOT_W = 16;  // sqrt(var), Q4.12 of a Q8.24 radicand
  localparam int RAD_W  = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;
  localparam int RES_W  = 32;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
  localparam logic [63:0]      LN2_Q32   = 64'd2977044472;
  localparam logic [63:0]      ONE_Q32   = 64'h1_0000_0000;

  localparam logic [IDX_W-1:0] REG_LENGTH_SCALE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIGNAL_VARIANCE = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUTPUT_MODE     = 2'd2;

  localparam logic [1:0] MODE_KERNEL = 2'd0;
  localparam logic [1:0] MODE_GRAD_L = 2'd1;
  localparam logic [1:0] MODE_GRAD_V = 2'd2;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_DEN  = 4'd1;   // latch l and 2*l*l
  localparam logic [3:0] OP_CLR  = 4'd2;   // take overflow flag, clear accumulator
  localparam logic [3:0] OP_T    = 4'd3;
  localparam logic [3:0] OP_U    = 4'd4;
  localparam logic [3:0] OP_TAB  = 4'd5;
  localparam logic [3:0] OP_M    = 4'd6;
  localparam logic [3:0] OP_E    = 4'd7;
  localparam logic [3:0] OP_P    = 4'd8;
  localparam logic [3:0] OP_PT   = 4'd9;
  localparam logic [3:0] OP_GRAD = 4'd10;
  localparam logic [3:0] OP_P2   = 4'd11;

  typedef struct packed {
    logic       accept;
    logic [3:0] op;
    logic       div_start;
    logic       div_grad;
    logic       sqrt_start;
    logic       out_load;
  } sek_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       sqrt_busy;
    logic [1:0] mode;
  } sek_sts_t;

  // 2^-(i/depth) in Q.32 from a truncated Taylor series of exp(-z), z in Q.32.
  function automatic logic [E_W-1:0] pow2_entry(input logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = ONE_Q32;
    term = ONE_Q32;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * z) >> 32) / 64'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[E_W-1:0];
  endfunction

endpackage

### rtl/sek_if.sv
// Valid/ready channel interfaces for coordinates in and kernel results out.
// Depends on nothing.
interface sek_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_coord;
  logic [15:0] y_coord;
  logic        last_coord;
  modport source (output valid, x_coord, y_coord, last_coord, input ready);
  modport sink (input valid, x_coord, y_coord, last_coord, output ready);
endinterface

interface sek_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] kernel_value;
  logic        saturated;
  modport source (output valid, kernel_value, saturated, input ready);
  modport sink (input valid, kernel_value, saturated, output ready);
endinterface

### rtl/sek_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on sek_pkg.
module sek_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sek_pkg::NUM_W-1:0]  num,
  input  logic [sek_pkg::DEN_W-1:0]  den,
  output logic [sek_pkg::NUM_W-1:0]  quo,
  output logic                       done
);
  localparam int CNT_W = $clog2(sek_pkg::NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sek_pkg::NUM_W - 1);

  logic [sek_pkg::NUM_W-1:0] quo_r, quo_nxt;
  logic [sek_pkg::DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r, done_r;
  logic [sek_pkg::DEN_W:0]   trial;

  always_comb begin
    trial   = {rem_r, quo_r[sek_pkg::NUM_W-1]};
    quo_nxt = {quo_r[sek_pkg::NUM_W-2:0], 1'b0};
    rem_nxt = trial[sek_pkg::DEN_W-1:0];
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = sek_pkg::DEN_W'(trial - {1'b0, den_r});
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule

### rtl/sek_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on sek_pkg.
module sek_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sek_pkg::RAD_W-1:0]   rad,
  output logic [sek_pkg::ROOT_W-1:0]  root,
  output logic                        busy
);
  localparam int CNT_W = $clog2(sek_pkg::ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sek_pkg::ROOT_W - 1);

  logic [sek_pkg::RAD_W-1:0]  rad_r;
  logic [sek_pkg::ROOT_W+1:0] rem_r;
  logic [sek_pkg::ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic [sek_pkg::ROOT_W+3:0] rem_t, trial;

  assign rem_t = {rem_r, rad_r[sek_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[sek_pkg::RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= (sek_pkg::ROOT_W+2)'(rem_t - trial);
        root_r <= {root_r[sek_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t[sek_pkg::ROOT_W+1:0];
        root_r <= {root_r[sek_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign busy = busy_r;
endmodule

### rtl/sek_dp.sv
// Datapath: configuration registers, distance accumulator, exponential
// table and result registers. Depends on sek_pkg, sek_div and sek_sqrt.
module sek_dp #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sek_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sek_pkg::CFG_W-1:0]         cfg_data,
  input  logic [15:0]                       in_x,
  input  logic [15:0]                       in_y,
  input  sek_pkg::sek_cmd_t                 cmd,
  output sek_pkg::sek_sts_t                 sts,
  output logic [sek_pkg::RES_W-1:0]         kernel_value,
  output logic                              saturated
);
  localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW = 16 + DW;

  logic [15:0] length_scale_r, signal_variance_r;
  logic [1:0]  output_mode_r;
  logic [sek_pkg::SUM_W-1:0] sum_r;
  logic        ovf_r, sat_r, big_r;
  logic [15:0] lsel_r;
  logic [sek_pkg::DEN_W-1:0] den_r;
  logic [sek_pkg::T_W-1:0]   t_r;
  logic [32:0] u_r;
  logic [16:0] n_r;
  logic [15:0] w_r;
  logic [sek_pkg::E_W-1:0] a_r, b_r, m_r, e_r;
  logic [sek_pkg::P_W-1:0] p_r;
  logic [sek_pkg::NUM_W-1:0] pt_r;
  logic [sek_pkg::RES_W-1:0] res_r, kernel_value_r;
  logic        saturated_r;

  logic [sek_pkg::E_W-1:0] tab [0:EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
    localparam logic [63:0] Z = (64'(gi) * sek_pkg::LN2_Q32) / 64'(EXP_TABLE_DEPTH);
    assign tab[gi] = sek_pkg::pow2_entry(Z);
  end

  // Squared difference of the incoming coordinate pair.
  logic signed [16:0] diff;
  logic [16:0]        adiff;
  logic [33:0]        sq;
  logic [sek_pkg::SUM_W:0] sum_add;
  assign diff    = 17'(signed'(in_x)) - 17'(signed'(in_y));
  assign adiff   = diff[16] ? 17'(-diff) : 17'(diff);
  assign sq      = 34'(adiff) * 34'(adiff);
  assign sum_add = {1'b0, sum_r} + (sek_pkg::SUM_W+1)'(sq);

  logic [15:0] l_eff;
  assign l_eff = (length_scale_r == 16'd0) ? 16'd1 : length_scale_r;

  // Divider and square root units.
  logic [sek_pkg::NUM_W-1:0]  div_num, div_q;
  logic [sek_pkg::DEN_W-1:0]  div_den;
  logic                       div_done, sqrt_busy;
  logic [sek_pkg::ROOT_W-1:0] root;

  assign div_num = cmd.div_grad ? pt_r : sek_pkg::NUM_W'({sum_r, 16'h0000});
  assign div_den = cmd.div_grad ? sek_pkg::DEN_W'({lsel_r, 7'd0}) : den_r;

  sek_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  sek_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   ({signal_variance_r, 16'h0000}),
    .root  (root),
    .busy  (sqrt_busy)
  );

  // Per-operation arithmetic.
  logic [49:0] u_prod;
  logic [PW-1:0] pos;
  logic [DW-1:0] idx;
  logic [sek_pkg::E_W-1:0] ab_diff;
  logic [48:0] m_prod;
  logic [48:0] p_prod;
  logic [48:0] p2_prod;
  logic        q_big;

  assign u_prod  = 50'(t_r) * 50'(sek_pkg::LOG2E_Q16);
  assign pos     = PW'(u_r[15:0]) * PW'(EXP_TABLE_DEPTH);
  assign idx     = pos[PW-1:16];
  assign ab_diff = a_r - b_r;
  assign m_prod  = 49'(ab_diff) * 49'(w_r);
  assign p_prod  = 49'(signal_variance_r) * 49'(e_r);
  assign p2_prod = 49'(root) * 49'(e_r);
  assign q_big   = |div_q[sek_pkg::NUM_W-1:sek_pkg::RES_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_scale_r    <= 16'd256;
      signal_variance_r <= 16'd256;
      output_mode_r     <= sek_pkg::MODE_KERNEL;
      sum_r             <= '0;
      ovf_r             <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sek_pkg::REG_LENGTH_SCALE:    length_scale_r    <= cfg_data;
          sek_pkg::REG_SIGNAL_VARIANCE: signal_variance_r <= cfg_data;
          sek_pkg::REG_OUTPUT_MODE:     output_mode_r     <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (sum_add[sek_pkg::SUM_W]) begin
          sum_r <= sek_pkg::SUM_MAX;
          ovf_r <= 1'b1;
        end else begin
          sum_r <= sum_add[sek_pkg::SUM_W-1:0];
        end
      end else if (cmd.op == sek_pkg::OP_CLR) begin
        sum_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sek_pkg::OP_DEN: begin
        lsel_r <= l_eff;
        den_r  <= sek_pkg::DEN_W'({32'(l_eff) * 32'(l_eff), 1'b0});
      end
      sek_pkg::OP_CLR: sat_r <= ovf_r;
      sek_pkg::OP_T: begin
        if (div_q > sek_pkg::NUM_W'(sek_pkg::ONE_Q32)) begin
          t_r <= sek_pkg::T_W'(sek_pkg::ONE_Q32);
        end else begin
          t_r <= div_q[sek_pkg::T_W-1:0];
        end
      end
      sek_pkg::OP_U: u_r <= u_prod[48:16];
      sek_pkg::OP_TAB: begin
        a_r <= tab[idx];
        b_r <= tab[DW'(idx + 1'b1)];
        w_r <= pos[15:0];
        n_r <= u_r[32:16];
      end
      sek_pkg::OP_M: m_r <= a_r - m_prod[48:16];
      sek_pkg::OP_E: e_r <= (n_r >= 17'd63) ? '0 : (m_r >> n_r[5:0]);
      sek_pkg::OP_P: begin
        p_r   <= p_prod[48:24];
        res_r <= sek_pkg::RES_W'(p_prod[48:24]);
        big_r <= 1'b0;
      end
      sek_pkg::OP_PT: pt_r <= sek_pkg::NUM_W'(p_r) * sek_pkg::NUM_W'(t_r);
      sek_pkg::OP_GRAD: begin
        res_r <= q_big ? {sek_pkg::RES_W{1'b1}} : div_q[sek_pkg::RES_W-1:0];
        big_r <= q_big;
      end
      sek_pkg::OP_P2: begin
        res_r <= sek_pkg::RES_W'(p2_prod[48:27]);
        big_r <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      kernel_value_r <= res_r;
      saturated_r    <= sat_r | big_r;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.sqrt_busy = sqrt_busy;
  assign sts.mode      = output_mode_r;
  assign kernel_value  = kernel_value_r;
  assign saturated     = saturated_r;
endmodule

### rtl/sek_ctrl.sv
// Controller: sequences the accumulate and the per-pair result tail and
// owns the channel handshakes. Depends on sek_pkg.
module sek_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sek_pkg::sek_sts_t sts,
  output sek_pkg::sek_cmd_t cmd
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DEN  = 4'd1;
  localparam logic [3:0] ST_DIV1 = 4'd2;
  localparam logic [3:0] ST_WT1  = 4'd3;
  localparam logic [3:0] ST_T    = 4'd4;
  localparam logic [3:0] ST_U    = 4'd5;
  localparam logic [3:0] ST_TAB  = 4'd6;
  localparam logic [3:0] ST_M    = 4'd7;
  localparam logic [3:0] ST_E    = 4'd8;
  localparam logic [3:0] ST_P    = 4'd9;
  localparam logic [3:0] ST_PT   = 4'd10;
  localparam logic [3:0] ST_DIV2 = 4'd11;
  localparam logic [3:0] ST_WT2  = 4'd12;
  localparam logic [3:0] ST_GRAD = 4'd13;
  localparam logic [3:0] ST_SQ   = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd.op    = sek_pkg::OP_DEN;
        state_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        // The divider and root unit take their operands before the clear.
        cmd.op         = sek_pkg::OP_CLR;
        cmd.div_start  = 1'b1;
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_WT1;
      end
      ST_WT1: if (sts.div_done) begin
        state_nxt = ST_T;
      end
      ST_T: begin
        cmd.op    = sek_pkg::OP_T;
        state_nxt = ST_U;
      end
      ST_U: begin
        cmd.op    = sek_pkg::OP_U;
        state_nxt = ST_TAB;
      end
      ST_TAB: begin
        cmd.op    = sek_pkg::OP_TAB;
        state_nxt = ST_M;
      end
      ST_M: begin
        cmd.op    = sek_pkg::OP_M;
        state_nxt = ST_E;
      end
      ST_E: begin
        cmd.op    = sek_pkg::OP_E;
        state_nxt = ST_P;
      end
      ST_P: begin
        cmd.op = sek_pkg::OP_P;
        if (sts.mode == sek_pkg::MODE_GRAD_L) begin
          state_nxt = ST_PT;
        end else if (sts.mode == sek_pkg::MODE_GRAD_V) begin
          state_nxt = ST_SQ;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_PT: begin
        cmd.op    = sek_pkg::OP_PT;
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_grad  = 1'b1;
        state_nxt     = ST_WT2;
      end
      ST_WT2: if (sts.div_done) begin
        state_nxt = ST_GRAD;
      end
      ST_GRAD: begin
        cmd.op    = sek_pkg::OP_GRAD;
        state_nxt = ST_OUT;
      end
      ST_SQ: if (!sts.sqrt_busy) begin
        cmd.op    = sek_pkg::OP_P2;
        state_nxt = ST_OUT;
      end
      ST_OUT: if (slot_free) begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

### rtl/squared_exponential_kernel_entry_top.sv
// Squared exponential kernel entry: one coordinate pair per input transaction,
// one kernel or gradient value per point pair on the output channel.
// Channels: in_if carries x_coord, y_coord (signed Q8.8) and last_coord;
// out_if carries kernel_value (unsigned Q16.16) and saturated.
// cfg_we/cfg_index/cfg_data write length_scale (0), signal_variance (1) and
// output_mode (2); write only while the block is idle.
// Coordinates that are not last are taken one per cycle. A last coordinate
// starts the result tail and in_if.ready stays low until it ends. The
// bit-serial divider (one quotient bit per cycle over 58 bits) dominates the
// tail; it computes r/(2l^2) and, in mode 1, the division by length scale.
// The result sits in an output register; the next pair's coordinates are
// accepted while it waits, and a stalled receiver only holds the block at
// the end of the following pair's tail.
// Reset (rst_n low, synchronous) clears the accumulator, restores the
// registers to l = 1.0, var = 1.0, mode 0, and drops out_if.valid.
module squared_exponential_kernel_entry_top #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sek_in_if.sink                          in_if,
  sek_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [sek_pkg::IDX_W-1:0]       cfg_index,
  input  logic [sek_pkg::CFG_W-1:0]       cfg_data
);
  sek_pkg::sek_cmd_t cmd;
  sek_pkg::sek_sts_t sts;

  sek_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last_coord),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sek_dp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_x         (in_if.x_coord),
    .in_y         (in_if.y_coord),
    .cmd          (cmd),
    .sts          (sts),
    .kernel_value (out_if.kernel_value),
    .saturated    (out_if.saturated)
  );

`ifndef SYNTHESIS
  // A coordinate that closes a pair starts the tail, which blocks input.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && in_if.last_coord |=> !in_if.ready)
    else $error("input still ready after the last coordinate of a pair");

  // Inner coordinates are accumulated without stalling the input.
  a_inner_streams: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && !in_if.last_coord |=> in_if.ready)
    else $error("input stalled after an inner coordinate");

  // A result is only loaded from the end of a tail, never from idle.
  a_result_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(!in_if.ready))
    else $error("result appeared without a finished tail");
`endif
endmodule
